@@ hw/rtl/mtrg_pkg.sv @@
// ----------------------------------------------------------------------------
// mtrg_pkg
// Shared constants, types and the tempering helper function of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtrg_pkg;

   localparam int STATE_WORDS    = 624;
   localparam int TAP_OFFSET     = 397;
   localparam int WORD_WIDTH     = 32;
   localparam int IDX_WIDTH      = $clog2(STATE_WORDS);
   localparam int POS_WIDTH      = $clog2(STATE_WORDS + 1);
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REQ_DATA_WIDTH = 8;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SEED_ADDR = CSR_ADDR_WIDTH'(0);

   localparam logic [WORD_WIDTH-1:0] SEED_RESET   = 32'd5489;
   localparam logic [WORD_WIDTH-1:0] SEED_MULT    = 32'd1812433253;
   localparam logic [WORD_WIDTH-1:0] TWIST_MATRIX = 32'h9908B0DF;
   localparam logic [WORD_WIDTH-1:0] TEMPER_B     = 32'h9D2C5680;
   localparam logic [WORD_WIDTH-1:0] TEMPER_C     = 32'hEFC60000;

   localparam logic [IDX_WIDTH-1:0] LAST_INDEX = IDX_WIDTH'(STATE_WORDS - 1);
   localparam logic [IDX_WIDTH-1:0] TAP_FWD    = IDX_WIDTH'(TAP_OFFSET);
   localparam logic [IDX_WIDTH-1:0] TAP_BACK   = IDX_WIDTH'(STATE_WORDS - TAP_OFFSET);
   localparam logic [POS_WIDTH-1:0] POS_END    = POS_WIDTH'(STATE_WORDS);

   typedef struct packed {
      logic seed_init;
      logic seed_mul;
      logic seed_add;
      logic tw_prime;
      logic tw_capture;
      logic tw_issue;
      logic tw_write;
      logic deliver;
   } mtrg_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic pos_end;
      logic out_busy;
   } mtrg_status_type;

   function automatic logic [WORD_WIDTH-1:0] temper(input logic [WORD_WIDTH-1:0] x);
      logic [WORD_WIDTH-1:0] y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

@@ hw/rtl/mtrg_ram.sv @@
// ----------------------------------------------------------------------------
// mtrg_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mtrg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

@@ hw/rtl/mtrg_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtrg_ctrl
// Sequencer for seeding, store twist and word fetch of the generator.
// ----------------------------------------------------------------------------
module mtrg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_request,
   output logic                     req_tready,
   input  logic                     seed_write,
   input  mtrg_pkg::mtrg_status_type status,
   output mtrg_pkg::mtrg_cmd_type   cmd
);

   typedef enum logic [9:0] {
      ST_SEED_INIT  = 10'b0000000001,
      ST_SEED_MUL   = 10'b0000000010,
      ST_SEED_ADD   = 10'b0000000100,
      ST_IDLE       = 10'b0000001000,
      ST_TW_PRIME   = 10'b0000010000,
      ST_TW_CAPTURE = 10'b0000100000,
      ST_TW_ISSUE   = 10'b0001000000,
      ST_TW_WRITE   = 10'b0010000000,
      ST_FETCH      = 10'b0100000000,
      ST_DELIVER    = 10'b1000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_SEED_INIT: begin
            cmd.seed_init = 1'b1;
            state_in      = ST_SEED_MUL;
         end
         ST_SEED_MUL: begin
            cmd.seed_mul = 1'b1;
            state_in     = ST_SEED_ADD;
         end
         ST_SEED_ADD: begin
            cmd.seed_add = 1'b1;
            state_in     = status.idx_last ? ST_IDLE : ST_SEED_MUL;
         end
         ST_IDLE: begin
            if (req_tvalid && req_request) begin
               state_in = status.pos_end ? ST_TW_PRIME : ST_FETCH;
            end
         end
         ST_TW_PRIME: begin
            cmd.tw_prime = 1'b1;
            state_in     = ST_TW_CAPTURE;
         end
         ST_TW_CAPTURE: begin
            cmd.tw_capture = 1'b1;
            state_in       = ST_TW_ISSUE;
         end
         ST_TW_ISSUE: begin
            cmd.tw_issue = 1'b1;
            state_in     = ST_TW_WRITE;
         end
         ST_TW_WRITE: begin
            cmd.tw_write = 1'b1;
            state_in     = status.idx_last ? ST_FETCH : ST_TW_ISSUE;
         end
         ST_FETCH: begin
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (!status.out_busy) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SEED_INIT;
         end
      endcase
      if (seed_write) begin
         state_in = ST_SEED_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SEED_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/mtrg_datapath.sv @@
// ----------------------------------------------------------------------------
// mtrg_datapath
// State store, seeding recurrence, twist unit, tempering and output register.
// ----------------------------------------------------------------------------
module mtrg_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mtrg_pkg::mtrg_cmd_type                cmd,
   input  logic                                  seed_write,
   input  logic [mtrg_pkg::WORD_WIDTH-1:0]       seed_wdata,
   output logic [mtrg_pkg::WORD_WIDTH-1:0]       seed_value,
   output mtrg_pkg::mtrg_status_type             status,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [mtrg_pkg::WORD_WIDTH-1:0]       rsp_tdata
);

   logic [mtrg_pkg::WORD_WIDTH-1:0] seed_ff, seed_in;
   logic [mtrg_pkg::WORD_WIDTH-1:0] w_ff, w_in;
   logic [mtrg_pkg::WORD_WIDTH-1:0] prod_ff, prod_in;
   logic [mtrg_pkg::WORD_WIDTH-1:0] cur_ff, cur_in;
   logic [mtrg_pkg::IDX_WIDTH-1:0]  idx_ff, idx_in;
   logic [mtrg_pkg::POS_WIDTH-1:0]  pos_ff, pos_in;
   logic                            out_valid_ff, out_valid_in;
   logic [mtrg_pkg::WORD_WIDTH-1:0] out_data_ff, out_data_in;

   logic [mtrg_pkg::WORD_WIDTH-1:0] seed0;
   logic [mtrg_pkg::WORD_WIDTH-1:0] mix;
   logic [mtrg_pkg::WORD_WIDTH-1:0] twist_y;
   logic [mtrg_pkg::WORD_WIDTH-1:0] twist_v;
   logic [mtrg_pkg::IDX_WIDTH-1:0]  nxt_idx;
   logic [mtrg_pkg::IDX_WIDTH-1:0]  tap_idx;

   logic                            ram_wr_en;
   logic [mtrg_pkg::IDX_WIDTH-1:0]  ram_wr_addr;
   logic [mtrg_pkg::WORD_WIDTH-1:0] ram_wr_data;
   logic [mtrg_pkg::IDX_WIDTH-1:0]  ram_rd_a_addr;
   logic [mtrg_pkg::WORD_WIDTH-1:0] ram_rd_a_data;
   logic [mtrg_pkg::WORD_WIDTH-1:0] ram_rd_b_data;

   // zero seed behaves as one
   assign seed0 = (seed_ff == '0) ? mtrg_pkg::WORD_WIDTH'(1) : seed_ff;
   assign mix   = w_ff ^ (w_ff >> 30);

   assign nxt_idx = (idx_ff == mtrg_pkg::LAST_INDEX) ? '0 : idx_ff + 1'b1;
   assign tap_idx = (idx_ff < mtrg_pkg::TAP_BACK) ? idx_ff + mtrg_pkg::TAP_FWD
                                                  : idx_ff - mtrg_pkg::TAP_BACK;

   assign twist_y = {cur_ff[mtrg_pkg::WORD_WIDTH-1], ram_rd_a_data[mtrg_pkg::WORD_WIDTH-2:0]};
   assign twist_v = ram_rd_b_data ^ (twist_y >> 1)
                  ^ (twist_y[0] ? mtrg_pkg::TWIST_MATRIX : '0);

   always_comb begin
      ram_wr_en   = cmd.seed_init | cmd.seed_add | cmd.tw_write;
      ram_wr_addr = cmd.seed_init ? '0 : idx_ff;
      priority if (cmd.seed_init) begin
         ram_wr_data = seed0;
      end else if (cmd.seed_add) begin
         ram_wr_data = w_in;
      end else begin
         ram_wr_data = twist_v;
      end
      priority if (cmd.tw_prime) begin
         ram_rd_a_addr = '0;
      end else if (cmd.tw_issue) begin
         ram_rd_a_addr = nxt_idx;
      end else begin
         ram_rd_a_addr = pos_ff[mtrg_pkg::IDX_WIDTH-1:0];
      end
   end

   always_comb begin
      seed_in      = seed_write ? seed_wdata : seed_ff;
      w_in         = w_ff;
      prod_in      = prod_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_data_in  = out_data_ff;
      if (cmd.seed_init) begin
         w_in   = seed0;
         idx_in = mtrg_pkg::IDX_WIDTH'(1);
         pos_in = mtrg_pkg::POS_END;
      end
      if (cmd.seed_mul) begin
         prod_in = mix * mtrg_pkg::SEED_MULT;
      end
      if (cmd.seed_add) begin
         w_in   = prod_ff + mtrg_pkg::WORD_WIDTH'(idx_ff);
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.tw_prime) begin
         idx_in = '0;
      end
      if (cmd.tw_capture) begin
         cur_in = ram_rd_a_data;
      end
      if (cmd.tw_write) begin
         cur_in = ram_rd_a_data;
         idx_in = idx_ff + 1'b1;
         if (idx_ff == mtrg_pkg::LAST_INDEX) begin
            pos_in = '0;
         end
      end
      if (cmd.deliver) begin
         out_valid_in = 1'b1;
         out_data_in  = mtrg_pkg::temper(ram_rd_a_data);
         pos_in       = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= mtrg_pkg::SEED_RESET;
         pos_ff       <= mtrg_pkg::POS_END;
         out_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      prod_ff     <= prod_in;
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      out_data_ff <= out_data_in;
   end

   mtrg_ram #(
      .WIDTH (mtrg_pkg::WORD_WIDTH),
      .DEPTH (mtrg_pkg::STATE_WORDS)
   ) u_store (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_a_addr (ram_rd_a_addr),
      .rd_a_data (ram_rd_a_data),
      .rd_b_addr (tap_idx),
      .rd_b_data (ram_rd_b_data)
   );

   assign status.idx_last = (idx_ff == mtrg_pkg::LAST_INDEX);
   assign status.pos_end  = (pos_ff == mtrg_pkg::POS_END);
   assign status.out_busy = out_valid_ff & ~rsp_tready;

   assign seed_value = seed_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= mtrg_pkg::POS_END)
      else $error("read position past end of store");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> !(out_valid_ff && !rsp_tready))
      else $error("result loaded while previous transaction still pending");

   a_fetch_not_at_end: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> (pos_ff != mtrg_pkg::POS_END))
      else $error("word fetched from exhausted store");

   a_twist_resets_pos: assert property (@(posedge clock) disable iff (reset)
      (cmd.tw_write && idx_ff == mtrg_pkg::LAST_INDEX) |=> (pos_ff == '0))
      else $error("read position not rewound after twist");
`endif

endmodule

@@ hw/rtl/mt19937_random_generator.sv @@
// a request taken in idle passes fetch (store read) and deliver, which loads the
// tempered word into the output register once the previous result is taken; only
// then is a new request accepted. The first word after seeding and every 624th
// after it first twist the store in place. Reset and every seed write run the
// seeding recurrence with req_tready low; csr writes are taken at all times
// ----------------------------------------------------------------------------
// mt19937_random_generator
// MT19937 pseudo-random word generator with an APB seed register.
// ----------------------------------------------------------------------------
module mt19937_random_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mtrg_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,   // [0] request
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mtrg_pkg::WORD_WIDTH-1:0]       rsp_tdata,   // [31:0] random_word
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mtrg_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [mtrg_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [mtrg_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   mtrg_pkg::mtrg_cmd_type          cmd;
   mtrg_pkg::mtrg_status_type       status;
   logic                            seed_sel;
   logic                            seed_write;
   logic [mtrg_pkg::WORD_WIDTH-1:0] seed_value;

   // registers are word aligned, bit 2 picks the register
   assign seed_sel   = (csr_paddr[2] == mtrg_pkg::CSR_SEED_ADDR[2]);
   assign seed_write = csr_psel & csr_penable & csr_pwrite & seed_sel;
   assign csr_pready = 1'b1;
   assign csr_prdata = seed_sel ? seed_value : '0;

   mtrg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_request (req_tdata[0]),
      .req_tready  (req_tready),
      .seed_write  (seed_write),
      .status      (status),
      .cmd         (cmd)
   );

   mtrg_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .seed_write (seed_write),
      .seed_wdata (csr_pwdata),
      .seed_value (seed_value),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ verif/tb_mt19937_random_generator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mt19937_random_generator
// Checks each returned word against a cycle-free MT19937 predictor kept in a
// scoreboard. Phases run on the reset seed, then on seeds written over APB: zero,
// all ones, random and one. Requests and results idle at random, and the
// result side holds off once for a long stretch to stall the input.
// ----------------------------------------------------------------------------

class mt_word_scoreboard;

   localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
   localparam logic [31:0] LOWER_MASK = 32'h7FFF_FFFF;

   logic [31:0] store [0:mtrg_pkg::STATE_WORDS-1];
   int unsigned position;
   logic [31:0] expected_words [$];
   int error_count;

   function new();
      error_count = 0;
      load_seed(mtrg_pkg::SEED_RESET);
   endfunction

   function void load_seed(logic [31:0] seed);
      logic [31:0] w;
      int i;
      w = (seed == 32'd0) ? 32'd1 : seed;
      store[0] = w;
      for (i = 1; i < mtrg_pkg::STATE_WORDS; i++) begin
         w = mtrg_pkg::SEED_MULT * (w ^ (w >> 30)) + 32'(i);
         store[i] = w;
      end
      position = mtrg_pkg::STATE_WORDS;
   endfunction

   function void twist();
      logic [31:0] y;
      logic [31:0] v;
      int i;
      for (i = 0; i < mtrg_pkg::STATE_WORDS; i++) begin
         y = (store[i] & UPPER_MASK)
           | (store[(i + 1) % mtrg_pkg::STATE_WORDS] & LOWER_MASK);
         v = store[(i + mtrg_pkg::TAP_OFFSET) % mtrg_pkg::STATE_WORDS] ^ (y >> 1);
         if (y[0]) begin
            v = v ^ mtrg_pkg::TWIST_MATRIX;
         end
         store[i] = v;
      end
      position = 0;
   endfunction

   // accepted request transaction
   function void note_request(logic request);
      logic [31:0] y;
      if (!request) begin
         return;
      end
      if (position >= mtrg_pkg::STATE_WORDS) begin
         twist();
      end
      y = store[position];
      position++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & mtrg_pkg::TEMPER_B);
      y = y ^ ((y << 15) & mtrg_pkg::TEMPER_C);
      y = y ^ (y >> 18);
      expected_words.push_back(y);
   endfunction

   // accepted result transaction
   function void check_word(logic [31:0] actual);
      logic [31:0] want;
      if (expected_words.size() == 0) begin
         $error("random_word: unexpected transaction, actual %h", actual);
         error_count++;
         return;
      end
      want = expected_words.pop_front();
      if (actual !== want) begin
         $error("random_word: expected %h, actual %h", want, actual);
         error_count++;
      end
   endfunction

endclass

module tb_mt19937_random_generator;

   import mtrg_pkg::*;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_UNUSED_ADDR = CSR_ADDR_WIDTH'(4);
   localparam int MAX_GAP       = 14;
   localparam int HOLD_AT_WORD  = 100;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 16;
   localparam int IDLE_LIMIT    = 20000;
   localparam logic [15:0] DIRECTED_REQS = 16'b1011_0111_1101_1010;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_WIDTH-1:0]  req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [WORD_WIDTH-1:0]      rsp_tdata;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]  csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_prdata;
   logic                       csr_pready;

   mt_word_scoreboard word_sb = new();
   logic [31:0] seed_written = SEED_RESET;
   int words_seen = 0;
   int idle_cycles = 0;

   mt19937_random_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic csr_access(input logic write, input logic [CSR_ADDR_WIDTH-1:0] addr,
                             input logic [CSR_DATA_WIDTH-1:0] wdata,
                             output logic [CSR_DATA_WIDTH-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_seed(input logic [CSR_ADDR_WIDTH-1:0] addr,
                             input logic [31:0] value);
      logic [CSR_DATA_WIDTH-1:0] unused;
      logic [CSR_DATA_WIDTH-1:0] readback;
      csr_access(1'b1, addr, value, unused);
      if (addr == CSR_SEED_ADDR) begin
         seed_written = value;
         word_sb.load_seed(value);
      end
      csr_access(1'b0, CSR_SEED_ADDR, '0, readback);
      if (readback !== seed_written) begin
         $error("seed_value: expected %h, actual %h", seed_written, readback);
         word_sb.error_count++;
      end
   endtask

   task automatic send_request(input logic request, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_WIDTH'(request);
      do @(posedge clock); while (!req_tready);
      word_sb.note_request(request);
   endtask

   // word_count counts only requests that ask for a word
   task automatic send_random(input int word_count);
      int sent;
      int n;
      logic request;
      sent = 0;
      n = 0;
      while (sent < word_count) begin
         request = ($urandom_range(0, 99) >= 10);
         send_request(request, ((n % 50) < 12) ? 0 : $urandom_range(0, MAX_GAP));
         if (request) begin
            sent++;
         end
         n++;
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (word_sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (words_seen == HOLD_AT_WORD) begin
            gap = HOLD_CYCLES;
         end else if ((words_seen % 40) < 10) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, MAX_GAP);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         word_sb.check_word(rsp_tdata);
         words_seen++;
      end
   end

   initial begin
      int i;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset seed, readback, then directed requests incl. request low
      write_seed(CSR_UNUSED_ADDR, 32'hDEAD_BEEF);
      for (i = 0; i < 16; i++) begin
         send_request(DIRECTED_REQS[i], (i % 3 == 2) ? MAX_GAP : 0);
      end
      req_tvalid <= 1'b0;
      wait_idle();

      // unknown register leaves the sequence running
      write_seed(CSR_UNUSED_ADDR, 32'hFFFF_FFFF);
      send_random(620);
      wait_idle();

      write_seed(CSR_SEED_ADDR, 32'h0000_0000);
      send_random(30);
      wait_idle();

      write_seed(CSR_SEED_ADDR, 32'hFFFF_FFFF);
      send_random(30);
      wait_idle();

      write_seed(CSR_SEED_ADDR, $urandom);
      send_random(30);
      wait_idle();

      write_seed(CSR_SEED_ADDR, 32'h0000_0001);
      send_random(30);
      wait_idle();

      if (word_sb.error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
